/* sv/assert_macros.svh */
// Assertion macros used by the checker file of the stream validator.
// Needs nothing else; every macro reports through $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is active.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Implication form: when cond holds, expr must hold in the same cycle.
`define ASSERT_IMPL(lbl, clk, rst_n, cond, expr) \
  `ASSERT_CLK(lbl, clk, rst_n, (cond) |-> (expr))

`endif

/* sv/fisv_pkg.sv */
// Package of the firmware image stream validator: codes, config record,
// SHA-256 constants and helpers. Used by all modules but the front queue.
`default_nettype none

package fisv_pkg;

  localparam int unsigned CHIP_OFFSET   = 12;
  localparam int unsigned PAD_ALIGN     = 16;
  localparam int unsigned TRAILER_BYTES = 32;
  localparam logic [15:0] NO_CHIP_CHECK = 16'hFFFF;

  // Configuration register indexes
  localparam logic [2:0] CFG_IMAGE_SIZE      = 3'd0;
  localparam logic [2:0] CFG_PARTITION_LIMIT = 3'd1;
  localparam logic [2:0] CFG_DEVICE_CHIP_ID  = 3'd2;
  localparam logic [2:0] CFG_MIN_IMAGE_SIZE  = 3'd3;
  localparam logic [2:0] CFG_MAGIC_VALUE     = 3'd4;
  localparam logic [2:0] CFG_CHECKSUM_SEED   = 3'd5;

  localparam logic [15:0] CHIP_ID_RST = 16'hFFFF;
  localparam logic [7:0]  MAGIC_RST   = 8'hE9;
  localparam logic [7:0]  SEED_RST    = 8'hEF;

  typedef enum logic [3:0] {
    ST_OK           = 4'd0,
    ST_TOO_SMALL    = 4'd1,
    ST_TOO_LARGE    = 4'd2,
    ST_BAD_MAGIC    = 4'd3,
    ST_BAD_CHIP     = 4'd4,
    ST_BAD_SEGMENTS = 4'd5,
    ST_BAD_SIZE     = 4'd6,
    ST_BAD_CHECKSUM = 4'd7,
    ST_BAD_SHA      = 4'd8,
    ST_READ_FAIL    = 4'd9
  } status_e;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_SEGHDR,
    PH_DATA,
    PH_PAD,
    PH_FINISH,
    PH_TRAILER,
    PH_DONE
  } phase_e;

  typedef enum logic [1:0] {
    FS_MARK,
    FS_ZERO,
    FS_LEN
  } fin_stage_e;

  typedef enum logic [1:0] {
    SHA_LOAD,
    SHA_ROUND,
    SHA_FOLD
  } sha_state_e;

  typedef struct packed {
    logic [24:0] image_size;
    logic [24:0] partition_limit;
    logic [15:0] device_chip_id;
    logic [24:0] min_image_size;
    logic [7:0]  magic_value;
    logic [7:0]  checksum_seed;
  } cfg_t;

  // Commands from the parser to the hash core
  typedef struct packed {
    logic       start;
    logic       load;
    logic [7:0] data;
  } sha_ctrl_t;

  // Status from the hash core to the parser
  typedef struct packed {
    logic       busy;
    logic [5:0] fill;
  } sha_stat_t;

  localparam logic [31:0] SHA_H0 [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

`default_nettype wire

/* sv/fisv_fifo.sv */
// Front queue of the validator: holds accepted byte transactions until the
// back end takes them. Depends on nothing but its parameters.
`default_nettype none

module fisv_fifo #(
  parameter int unsigned WIDTH = 9,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] push_data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output logic [WIDTH-1:0]      pop_data_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [AW:0]      cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o     = (cnt_q == (AW+1)'(DEPTH));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + (AW+1)'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the incoming transaction
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

/* sv/fisv_sha.sv */
// SHA-256 core of the validator: takes message bytes one at a time and runs
// one round per cycle on each full block. Depends on fisv_pkg.
`default_nettype none

module fisv_sha
  import fisv_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire sha_ctrl_t ctrl_i,
  output sha_stat_t      stat_o,
  output logic [255:0]   digest_o
);

  sha_state_e  state_q, state_d;
  logic [31:0] hash_q [8];
  logic [31:0] hash_d [8];
  logic [31:0] v_q [8];
  logic [31:0] v_d [8];
  logic [511:0] win_q, win_d;
  logic [5:0]  fill_q, fill_d;
  logic [5:0]  rnd_q, rnd_d;

  logic [31:0] w0, w1, w9, w14, w_new;
  logic [31:0] big_s0, big_s1, ch, maj, t1, t2, sm_s0, sm_s1;

  assign stat_o.busy = (state_q != SHA_LOAD);
  assign stat_o.fill = fill_q;

  for (genvar g = 0; g < 8; g++) begin : g_dig
    assign digest_o[255 - 32*g -: 32] = hash_q[g];
  end

  // Round function and message schedule
  always_comb begin
    w0     = win_q[511:480];
    w1     = win_q[479:448];
    w9     = win_q[223:192];
    w14    = win_q[63:32];
    sm_s0  = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
    sm_s1  = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
    w_new  = w0 + sm_s0 + w9 + sm_s1;
    big_s1 = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
    ch     = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    t1     = v_q[7] + big_s1 + ch + SHA_K[rnd_q] + w0;
    big_s0 = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
    maj    = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t2     = big_s0 + maj;
  end

  // Sequence load, rounds and fold
  always_comb begin
    state_d = state_q;
    hash_d  = hash_q;
    v_d     = v_q;
    win_d   = win_q;
    fill_d  = fill_q;
    rnd_d   = rnd_q;
    case (state_q)
      SHA_LOAD: begin
        if (ctrl_i.load) begin
          win_d  = {win_q[503:0], ctrl_i.data};
          fill_d = fill_q + 6'd1;
          if (fill_q == 6'd63) begin
            state_d = SHA_ROUND;
            rnd_d   = '0;
            v_d     = hash_q;
          end
        end
      end
      SHA_ROUND: begin
        win_d = {win_q[479:0], w_new};
        v_d[7] = v_q[6];
        v_d[6] = v_q[5];
        v_d[5] = v_q[4];
        v_d[4] = v_q[3] + t1;
        v_d[3] = v_q[2];
        v_d[2] = v_q[1];
        v_d[1] = v_q[0];
        v_d[0] = t1 + t2;
        rnd_d  = rnd_q + 6'd1;
        if (rnd_q == 6'd63) begin
          state_d = SHA_FOLD;
        end
      end
      SHA_FOLD: begin
        for (int i = 0; i < 8; i++) begin
          hash_d[i] = hash_q[i] + v_q[i];
        end
        state_d = SHA_LOAD;
      end
      default: state_d = SHA_LOAD;
    endcase
    // Restart on a new image, dropping any block in flight
    if (ctrl_i.start) begin
      state_d = SHA_LOAD;
      fill_d  = '0;
      hash_d  = SHA_H0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SHA_LOAD;
      fill_q  <= '0;
      rnd_q   <= '0;
      hash_q  <= SHA_H0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      rnd_q   <= rnd_d;
      hash_q  <= hash_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    win_q <= win_d;
  end

endmodule

`default_nettype wire

/* sv/fisv_parse.sv */
// Back end of the validator: walks the image layout byte by byte, feeds the
// hash core and holds the verdict register. Depends on fisv_pkg, fisv_sha.
`default_nettype none

module fisv_parse
  import fisv_pkg::*;
#(
  parameter int unsigned HEADER_BYTES         = 24,
  parameter int unsigned SEGMENT_HEADER_BYTES = 8,
  parameter int unsigned SIZE_BITS            = 24
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cfg_t        cfg_i,
  input  wire logic        item_valid_i,
  input  wire logic [7:0]  item_byte_i,
  input  wire logic        item_last_i,
  output logic             item_pop_o,
  output logic             res_valid_o,
  input  wire logic        res_ready_i,
  output logic [3:0]       res_status_o,
  output logic [24:0]      res_offset_o
);

  localparam int unsigned SW = $clog2(SEGMENT_HEADER_BYTES + 1);

  typedef struct packed {
    logic        fail;
    status_e     st;
    phase_e      ph;
    logic [31:0] left;
  } next_t;

  phase_e      phase_q, phase_d;
  fin_stage_e  fin_q, fin_d;
  logic [24:0] off_q, off_d;
  logic [7:0]  seg_q, seg_d;
  logic [31:0] field_q, field_d;
  logic [31:0] left_q, left_d;
  logic [7:0]  xor_q, xor_d;
  logic        trl_q, trl_d;
  logic [15:0] chip_q, chip_d;
  logic        magic_q, magic_d;
  logic        mism_q, mism_d;
  logic [2:0]  lidx_q, lidx_d;
  logic [25:0] fpos_q, fpos_d;
  logic        out_valid_q, out_valid_d;
  logic [3:0]  out_st_q, out_st_d;
  logic [24:0] out_off_q, out_off_d;

  sha_ctrl_t    sha_ctrl;
  sha_stat_t    sha_stat;
  logic [255:0] digest;

  logic        pop, res_v, mism_n, pad_fail;
  status_e     res_st;
  logic [25:0] pos;
  logic [SW-1:0] k;
  logic [4:0]  tidx;
  logic [7:0]  dbyte, lbyte;
  logic [63:0] lbits;
  logic [32:0] seg_end;
  next_t       nx;

  fisv_sha u_sha (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (sha_ctrl),
    .stat_o  (sha_stat),
    .digest_o(digest)
  );

  // Decide where the image goes after the header or a segment ends
  function automatic next_t next_seg(input logic [25:0] p, input logic [7:0] segs,
                                     input logic trl, input logic [24:0] size);
    next_t       r;
    logic [26:0] pad_end, expect_sz;
    r = '{fail: 1'b0, st: ST_OK, ph: PH_PAD, left: '0};
    if (segs == '0) begin
      pad_end   = ({1'b0, p} + 27'(PAD_ALIGN)) & ~27'(PAD_ALIGN - 1);
      expect_sz = pad_end + (trl ? 27'(TRAILER_BYTES) : 27'd0);
      if (expect_sz != {2'b0, size}) begin
        r.fail = 1'b1;
        r.st   = ST_BAD_SIZE;
      end else begin
        r.ph   = PH_PAD;
        r.left = 32'(pad_end - {1'b0, p});
      end
    end else if (({1'b0, p} + 27'(SEGMENT_HEADER_BYTES)) > {2'b0, size}) begin
      r.fail = 1'b1;
      r.st   = ST_BAD_SEGMENTS;
    end else begin
      r.ph   = PH_SEGHDR;
      r.left = 32'(SEGMENT_HEADER_BYTES);
    end
    return r;
  endfunction

  assign pop = item_valid_i && !sha_stat.busy && (phase_q != PH_FINISH) &&
               (!out_valid_q || res_ready_i);
  assign item_pop_o   = pop;
  assign res_valid_o  = out_valid_q;
  assign res_status_o = out_st_q;
  assign res_offset_o = out_off_q;

  assign pos     = {1'b0, off_q} + 26'd1;
  assign k       = SW'(SEGMENT_HEADER_BYTES) - left_q[SW-1:0];
  assign tidx    = 5'(6'd32 - left_q[5:0]);
  assign dbyte   = 8'(digest >> {5'd31 - tidx, 3'b000});
  assign lbits   = {35'd0, fpos_q, 3'b000};
  assign lbyte   = 8'(lbits >> {lidx_q, 3'b000});
  assign pad_fail = (cfg_i.image_size < cfg_i.min_image_size);

  // Parse one byte, or generate hash padding after the last pad byte
  always_comb begin
    phase_d  = phase_q;
    fin_d    = fin_q;
    off_d    = off_q;
    seg_d    = seg_q;
    field_d  = field_q;
    left_d   = left_q;
    xor_d    = xor_q;
    trl_d    = trl_q;
    chip_d   = chip_q;
    magic_d  = magic_q;
    mism_d   = mism_q;
    lidx_d   = lidx_q;
    fpos_d   = fpos_q;
    sha_ctrl = '{start: 1'b0, load: 1'b0, data: item_byte_i};
    res_v    = 1'b0;
    res_st   = ST_OK;
    mism_n   = mism_q;
    seg_end  = {7'd0, pos} + {1'b0, field_d};
    nx       = next_seg(pos, seg_q, trl_q, cfg_i.image_size);

    if (pop) begin
      case (phase_q)
        PH_HEADER: begin
          if (off_q == '0 && pad_fail) begin
            res_v  = 1'b1;
            res_st = ST_TOO_SMALL;
          end else if (off_q == '0 && cfg_i.partition_limit != '0 &&
                       cfg_i.image_size > cfg_i.partition_limit) begin
            res_v  = 1'b1;
            res_st = ST_TOO_LARGE;
          end else if (off_q == '0 &&
                       {8'd0, cfg_i.image_size} > (33'd1 << SIZE_BITS)) begin
            res_v  = 1'b1;
            res_st = ST_TOO_LARGE;
          end else if (off_q == '0 && cfg_i.image_size < 25'(HEADER_BYTES)) begin
            res_v  = 1'b1;
            res_st = ST_READ_FAIL;
          end else begin
            sha_ctrl.load = 1'b1;
            if (off_q == 25'd0) magic_d = (item_byte_i == cfg_i.magic_value);
            if (off_q == 25'd1) seg_d = item_byte_i;
            if (off_q == 25'(CHIP_OFFSET)) chip_d = {8'd0, item_byte_i};
            if (off_q == 25'(CHIP_OFFSET + 1)) chip_d[15:8] = item_byte_i;
            if (off_q == 25'(HEADER_BYTES - 1)) begin
              trl_d = (item_byte_i != '0);
              nx    = next_seg(pos, seg_q, trl_d, cfg_i.image_size);
              if (!magic_q) begin
                res_v  = 1'b1;
                res_st = ST_BAD_MAGIC;
              end else if (cfg_i.device_chip_id != NO_CHIP_CHECK &&
                           chip_q != cfg_i.device_chip_id) begin
                res_v  = 1'b1;
                res_st = ST_BAD_CHIP;
              end else if (nx.fail) begin
                res_v  = 1'b1;
                res_st = nx.st;
              end else begin
                phase_d = nx.ph;
                left_d  = nx.left;
                field_d = '0;
              end
            end
          end
        end
        PH_SEGHDR: begin
          sha_ctrl.load = 1'b1;
          if (k >= SW'(4) && k < SW'(8)) begin
            field_d[{k[1:0], 3'b000} +: 8] = item_byte_i;
          end
          seg_end = {7'd0, pos} + {1'b0, field_d};
          left_d  = left_q - 32'd1;
          if (left_q == 32'd1) begin
            if (seg_end > {8'd0, cfg_i.image_size}) begin
              res_v  = 1'b1;
              res_st = ST_BAD_SEGMENTS;
            end else if (field_d == '0) begin
              seg_d = seg_q - 8'd1;
              nx    = next_seg(pos, seg_d, trl_q, cfg_i.image_size);
              if (nx.fail) begin
                res_v  = 1'b1;
                res_st = nx.st;
              end else begin
                phase_d = nx.ph;
                left_d  = nx.left;
                field_d = '0;
              end
            end else begin
              left_d  = field_d;
              phase_d = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          sha_ctrl.load = 1'b1;
          xor_d  = xor_q ^ item_byte_i;
          left_d = left_q - 32'd1;
          if (left_q == 32'd1) begin
            seg_d = seg_q - 8'd1;
            nx    = next_seg(pos, seg_d, trl_q, cfg_i.image_size);
            if (nx.fail) begin
              res_v  = 1'b1;
              res_st = nx.st;
            end else begin
              phase_d = nx.ph;
              left_d  = nx.left;
              field_d = '0;
            end
          end
        end
        PH_PAD: begin
          sha_ctrl.load = 1'b1;
          left_d = left_q - 32'd1;
          if (left_q == 32'd1) begin
            if (item_byte_i != xor_q) begin
              res_v  = 1'b1;
              res_st = ST_BAD_CHECKSUM;
            end else if (!trl_q) begin
              res_v  = 1'b1;
              res_st = ST_OK;
            end else begin
              phase_d = PH_FINISH;
              fin_d   = FS_MARK;
              fpos_d  = pos;
            end
          end
        end
        PH_TRAILER: begin
          mism_n = mism_q | (dbyte != item_byte_i);
          mism_d = mism_n;
          left_d = left_q - 32'd1;
          if (left_q == 32'd1) begin
            res_v  = 1'b1;
            res_st = mism_n ? ST_BAD_SHA : ST_OK;
          end
        end
        default: ;
      endcase

      // End marker before any verdict is a short read
      if (item_last_i && !res_v && phase_q != PH_DONE) begin
        res_v  = 1'b1;
        res_st = ST_READ_FAIL;
      end
      if (res_v) begin
        phase_d = PH_DONE;
      end
      off_d = off_q + 25'd1;

      // Rearm for the next image on the end marker
      if (item_last_i) begin
        off_d    = '0;
        phase_d  = PH_HEADER;
        seg_d    = '0;
        field_d  = '0;
        left_d   = '0;
        xor_d    = cfg_i.checksum_seed;
        trl_d    = 1'b0;
        chip_d   = '0;
        magic_d  = 1'b0;
        mism_d   = 1'b0;
        sha_ctrl.start = 1'b1;
      end
    end else if (phase_q == PH_FINISH && !sha_stat.busy) begin
      case (fin_q)
        FS_MARK: begin
          sha_ctrl.load = 1'b1;
          sha_ctrl.data = 8'h80;
          fin_d = FS_ZERO;
        end
        FS_ZERO: begin
          if (sha_stat.fill == 6'd56) begin
            fin_d  = FS_LEN;
            lidx_d = 3'd7;
          end else begin
            sha_ctrl.load = 1'b1;
            sha_ctrl.data = 8'h00;
          end
        end
        FS_LEN: begin
          sha_ctrl.load = 1'b1;
          sha_ctrl.data = lbyte;
          lidx_d = lidx_q - 3'd1;
          if (lidx_q == 3'd0) begin
            phase_d = PH_TRAILER;
            left_d  = 32'(TRAILER_BYTES);
            mism_d  = 1'b0;
          end
        end
        default: fin_d = FS_MARK;
      endcase
    end
  end

  // Load or release the verdict register
  always_comb begin
    out_valid_d = out_valid_q;
    out_st_d    = out_st_q;
    out_off_d   = out_off_q;
    if (pop && res_v) begin
      out_valid_d = 1'b1;
      out_st_d    = 4'(res_st);
      out_off_d   = off_q;
    end else if (res_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      fin_q       <= FS_MARK;
      off_q       <= '0;
      seg_q       <= '0;
      field_q     <= '0;
      left_q      <= '0;
      xor_q       <= SEED_RST;
      trl_q       <= 1'b0;
      chip_q      <= '0;
      magic_q     <= 1'b0;
      mism_q      <= 1'b0;
      lidx_q      <= '0;
      fpos_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      fin_q       <= fin_d;
      off_q       <= off_d;
      seg_q       <= seg_d;
      field_q     <= field_d;
      left_q      <= left_d;
      xor_q       <= xor_d;
      trl_q       <= trl_d;
      chip_q      <= chip_d;
      magic_q     <= magic_d;
      mism_q      <= mism_d;
      lidx_q      <= lidx_d;
      fpos_q      <= fpos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_st_q  <= out_st_d;
    out_off_q <= out_off_d;
  end

endmodule

`default_nettype wire

/* sv/firmware_image_stream_validator.sv */
// When idle, a verdict shows on the master side once its byte has passed the front queue and the verdict register.
// The front queue takes one byte per cycle while it is not full; the back end takes one byte a
// cycle, but stops while the SHA-256 round unit works on each 64-byte block or a verdict is held.
// A trailer adds hash padding and the final hash blocks before its bytes are checked.
// Reset: rst_ni, asynchronous active low, clears control state and loads config defaults.
`default_nettype none

module firmware_image_stream_validator
  import fisv_pkg::*;
#(
  parameter int unsigned HEADER_BYTES         = 24,
  parameter int unsigned SEGMENT_HEADER_BYTES = 8,
  parameter int unsigned SIZE_BITS            = 24,
  parameter int unsigned FIFO_DEPTH           = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tlast,   // end_of_stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [3:0] status, [28:4] verdict_offset, rest 0
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [24:0] cfg_data_i
);

  cfg_t        cfg_q, cfg_d;
  logic        q_full, q_valid, q_pop;
  logic [8:0]  q_data;
  logic [3:0]  res_status;
  logic [24:0] res_offset;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !q_full;

  // Write configuration registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_IMAGE_SIZE:      cfg_d.image_size      = cfg_data_i;
        CFG_PARTITION_LIMIT: cfg_d.partition_limit = cfg_data_i;
        CFG_DEVICE_CHIP_ID:  cfg_d.device_chip_id  = cfg_data_i[15:0];
        CFG_MIN_IMAGE_SIZE:  cfg_d.min_image_size  = cfg_data_i;
        CFG_MAGIC_VALUE:     cfg_d.magic_value     = cfg_data_i[7:0];
        CFG_CHECKSUM_SEED:   cfg_d.checksum_seed   = cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{image_size: '0, partition_limit: '0, device_chip_id: CHIP_ID_RST,
                 min_image_size: '0, magic_value: MAGIC_RST, checksum_seed: SEED_RST};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  fisv_fifo #(
    .WIDTH(9),
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (s_axis_tvalid),
    .push_data_i({s_axis_tlast, s_axis_tdata}),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .pop_data_o (q_data)
  );

  fisv_parse #(
    .HEADER_BYTES        (HEADER_BYTES),
    .SEGMENT_HEADER_BYTES(SEGMENT_HEADER_BYTES),
    .SIZE_BITS           (SIZE_BITS)
  ) u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .item_valid_i(q_valid),
    .item_byte_i (q_data[7:0]),
    .item_last_i (q_data[8]),
    .item_pop_o  (q_pop),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_status_o(res_status),
    .res_offset_o(res_offset)
  );

  assign m_axis_tdata = {3'b000, res_offset, res_status};

endmodule

`default_nettype wire

/* sv/fisv_checker.sv */
// Port-level checker for the validator, bound to the top level.
// Depends on fisv_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module fisv_checker
  import fisv_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata
);

  // Hold a stalled verdict transaction
  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
  // Status stays within the defined codes
  `ASSERT_IMPL(a_status_range, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[3:0] <= 4'(ST_READ_FAIL))
  // Size verdicts fall on the first byte
  `ASSERT_IMPL(a_size_at_start, clk_i, rst_ni, m_axis_tvalid && (m_axis_tdata[3:0] == 4'(ST_TOO_SMALL) || m_axis_tdata[3:0] == 4'(ST_TOO_LARGE)), m_axis_tdata[28:4] == 25'd0)
  // Fill bits stay zero
  `ASSERT_IMPL(a_pad_zero, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[31:29] == 3'b000)

endmodule

bind firmware_image_stream_validator fisv_checker u_fisv_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

`default_nettype wire
